// ===== rtl/core/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Window geometry.
  localparam int MaxWindow = 16;
  localparam int SlotBits  = $clog2(MaxWindow);
  localparam int CntBits   = SlotBits + 1;
  localparam int SeqBits   = 16;
  localparam int EdgeBits  = SeqBits + 1;
  localparam int WinBits   = 5;

  // Configuration register indexes.
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegWindow = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegTotal  = 1'd1;

  // Input command codes.
  localparam logic [1:0] CmdSend    = 2'd0;
  localparam logic [1:0] CmdAck     = 2'd1;
  localparam logic [1:0] CmdRestart = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KindFrame = 2'd0;
  localparam logic [1:0] KindAck   = 2'd1;
  localparam logic [1:0] KindIdle  = 2'd2;

  // Selects which frame number addresses the mark ring.
  localparam logic [1:0] RdNext = 2'd0;
  localparam logic [1:0] RdAck  = 2'd1;
  localparam logic [1:0] RdBase = 2'd2;

  typedef struct packed {
    logic       load;
    logic       restart;
    logic       send_step;
    logic       flush;
    logic       mark;
    logic       slide_step;
    logic       report;
    logic [1:0] rd_sel;
  } srsw_cmd_t;

  typedef struct packed {
    logic send_more;
    logic push_need;
    logic ack_ok;
    logic slide_more;
    logic out_free;
  } srsw_status_t;

endpackage

// ===== rtl/core/srsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer for send passes, acknowledgments and restarts.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  srsw_pkg::srsw_status_t status_i,
  output srsw_pkg::srsw_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSend   = 3'd1;
  localparam logic [2:0] StFlush  = 3'd2;
  localparam logic [2:0] StCheck  = 3'd3;
  localparam logic [2:0] StSlide  = 3'd4;
  localparam logic [2:0] StReport = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = srsw_pkg::RdBase;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (command_i)
            srsw_pkg::CmdSend:    state_d = StSend;
            srsw_pkg::CmdAck:     state_d = StCheck;
            srsw_pkg::CmdRestart: cmd_o.restart = 1'b1;
            default:              state_d = StIdle;
          endcase
        end
      end
      StSend: begin
        cmd_o.rd_sel = srsw_pkg::RdNext;
        if (status_i.send_more) begin
          // A frame that displaces the pending one needs the output register.
          if (!(status_i.push_need && !status_i.out_free)) begin
            cmd_o.send_step = 1'b1;
          end
        end else begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      StCheck: begin
        cmd_o.rd_sel = srsw_pkg::RdAck;
        if (status_i.ack_ok) begin
          cmd_o.mark = 1'b1;
          state_d    = StSlide;
        end else begin
          state_d = StReport;
        end
      end
      StSlide: begin
        if (status_i.slide_more) begin
          cmd_o.slide_step = 1'b1;
        end else begin
          state_d = StReport;
        end
      end
      StReport: begin
        if (status_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== rtl/core/srsw_datapath.sv =====
// ----------------------------------------------------------------------------
// srsw_datapath
// Window registers, acknowledgment ring, pending frame and output register.
// ----------------------------------------------------------------------------
module srsw_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [srsw_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [srsw_pkg::SeqBits-1:0]          cfg_data_i,
  input  logic [srsw_pkg::SeqBits-1:0]          ack_frame_i,
  input  srsw_pkg::srsw_cmd_t                   cmd_i,
  output srsw_pkg::srsw_status_t                status_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [1:0]                            kind_o,
  output logic [srsw_pkg::SeqBits-1:0]          frame_number_o,
  output logic [srsw_pkg::SeqBits-1:0]          send_base_o,
  output logic                                  accepted_o,
  output logic                                  all_done_o,
  output logic                                  last_o
);

  localparam int SeqBits  = srsw_pkg::SeqBits;
  localparam int SlotBits = srsw_pkg::SlotBits;
  localparam int CntBits  = srsw_pkg::CntBits;
  localparam int EdgeBits = srsw_pkg::EdgeBits;
  localparam int WinBits  = srsw_pkg::WinBits;

  logic [WinBits-1:0]            window_q;
  logic [SeqBits-1:0]            total_q;
  logic [SeqBits-1:0]            base_q, base_d;
  logic [SeqBits-1:0]            next_q, next_d;
  logic [srsw_pkg::MaxWindow-1:0] marks_q, marks_d;
  logic [SeqBits-1:0]            ackf_q;
  logic [CntBits-1:0]            cnt_q, cnt_d;
  logic                          pend_valid_q, pend_valid_d;
  logic [SeqBits-1:0]            pend_frame_q;
  logic                          acc_q, acc_d;
  logic                          out_valid_q;

  logic [WinBits-1:0]  w_eff;
  logic [EdgeBits-1:0] edge_full, edge_clip;
  logic [SlotBits-1:0] rd_slot;
  logic                mark_rd;
  logic                iter_left;
  logic                base_open;
  logic                out_free;
  logic                push_frame;
  logic                out_load;

  // Window size, clamped to the range the ring can cover.
  always_comb begin
    if (window_q == '0) begin
      w_eff = WinBits'(1);
    end else if (window_q > WinBits'(srsw_pkg::MaxWindow)) begin
      w_eff = WinBits'(srsw_pkg::MaxWindow);
    end else begin
      w_eff = window_q;
    end
  end

  assign edge_full = {1'b0, base_q} + EdgeBits'(w_eff);
  assign edge_clip = (edge_full > {1'b0, total_q}) ? {1'b0, total_q} : edge_full;

  always_comb begin
    unique case (cmd_i.rd_sel)
      srsw_pkg::RdNext: rd_slot = next_q[SlotBits-1:0];
      srsw_pkg::RdAck:  rd_slot = ackf_q[SlotBits-1:0];
      default:          rd_slot = base_q[SlotBits-1:0];
    endcase
  end

  assign mark_rd   = marks_q[rd_slot];
  assign iter_left = (cnt_q < CntBits'(srsw_pkg::MaxWindow));
  assign base_open = (base_q < total_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign status_o.send_more  = iter_left && ({1'b0, next_q} < edge_clip);
  assign status_o.push_need  = !mark_rd && pend_valid_q;
  assign status_o.ack_ok     = (ackf_q >= base_q) && ({1'b0, ackf_q} < edge_full) &&
                               (ackf_q < total_q) && !mark_rd;
  assign status_o.slide_more = iter_left && base_open && mark_rd;
  assign status_o.out_free   = out_free;

  assign push_frame = cmd_i.send_step && !mark_rd && pend_valid_q;
  assign out_load   = push_frame || cmd_i.flush || cmd_i.report;

  always_comb begin
    base_d       = base_q;
    next_d       = next_q;
    marks_d      = marks_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    acc_d        = acc_q;
    if (cmd_i.load) begin
      cnt_d        = '0;
      pend_valid_d = 1'b0;
      acc_d        = 1'b0;
    end
    if (cmd_i.restart) begin
      base_d  = '0;
      next_d  = '0;
      marks_d = '0;
    end
    if (cmd_i.send_step) begin
      next_d = next_q + SeqBits'(1);
      cnt_d  = cnt_q + CntBits'(1);
      if (!mark_rd) begin
        pend_valid_d = 1'b1;
      end
    end
    if (cmd_i.mark) begin
      marks_d[ackf_q[SlotBits-1:0]] = 1'b1;
      acc_d = 1'b1;
    end
    if (cmd_i.slide_step) begin
      marks_d[base_q[SlotBits-1:0]] = 1'b0;
      base_d = base_q + SeqBits'(1);
      cnt_d  = cnt_q + CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WinBits'(4);
      total_q      <= SeqBits'(10);
      base_q       <= '0;
      next_q       <= '0;
      marks_q      <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      acc_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          srsw_pkg::RegWindow: window_q <= cfg_data_i[WinBits-1:0];
          srsw_pkg::RegTotal:  total_q  <= cfg_data_i;
          default:             window_q <= window_q;
        endcase
      end
      base_q       <= base_d;
      next_q       <= next_d;
      marks_q      <= marks_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      acc_q        <= acc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ackf_q <= ack_frame_i;
    end
    if (cmd_i.send_step && !mark_rd) begin
      pend_frame_q <= next_q;
    end
    if (out_load) begin
      send_base_o <= base_q;
      all_done_o  <= !base_open;
      if (cmd_i.report) begin
        kind_o         <= srsw_pkg::KindAck;
        frame_number_o <= '0;
        accepted_o     <= acc_q;
        last_o         <= 1'b1;
      end else if (cmd_i.flush && !pend_valid_q) begin
        kind_o         <= srsw_pkg::KindIdle;
        frame_number_o <= '0;
        accepted_o     <= 1'b0;
        last_o         <= 1'b1;
      end else begin
        // The held frame is final only when the pass ends without another.
        kind_o         <= srsw_pkg::KindFrame;
        frame_number_o <= pend_frame_q;
        accepted_o     <= 1'b0;
        last_o         <= cmd_i.flush;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/selective_repeat_sender_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat ARQ link.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A send pass scans one frame number per
// cycle, unless a displaced frame waits for a busy output register, over at
// most 16 frame numbers and then flushes the held frame; an acknowledgment
// is checked and then reported if refused, or marked, followed by a slide of
// the base over the marked slots and a report if accepted; a restart is done
// in the idle state. Each result word leaves through a single output register,
// so a stalled output holds the send, flush and report steps. The base slide
// and the send scan both run through the same one-slot-per-cycle access to the mark ring.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srsw_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [srsw_pkg::SeqBits-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [srsw_pkg::SeqBits-1:0]        ack_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          kind_o,
  output logic [srsw_pkg::SeqBits-1:0]        frame_number_o,
  output logic [srsw_pkg::SeqBits-1:0]        send_base_o,
  output logic                                accepted_o,
  output logic                                all_done_o,
  output logic                                last_o
);

  srsw_pkg::srsw_cmd_t    cmd;
  srsw_pkg::srsw_status_t status;

  assign cfg_ready_o = 1'b1;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srsw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ack_frame_i    (ack_frame_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .frame_number_o (frame_number_o),
    .send_base_o    (send_base_o),
    .accepted_o     (accepted_o),
    .all_done_o     (all_done_o),
    .last_o         (last_o)
  );

  // An idle result is a single word with no frame number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == srsw_pkg::KindIdle) |-> last_o && (frame_number_o == '0))
    else $error("idle result malformed");

  // Ack status is always the only word of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == srsw_pkg::KindAck) |-> last_o)
    else $error("ack status without last");

  // Only an ack status can report an accepted acknowledgment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> (kind_o == srsw_pkg::KindAck))
    else $error("accepted flag on a non-ack result");

  // A send pass or acknowledgment keeps the input side closed afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    ((command_i == srsw_pkg::CmdSend) || (command_i == srsw_pkg::CmdAck)) |=> in_stall_o)
    else $error("input accepted while busy");

endmodule

// ===== test/selective_repeat_sender_window_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_checker
// Passive checker for the selective-repeat sender window. It follows the
// register writes and the accepted commands, keeps its own copy of the
// window state, queues the words that each command should produce and
// compares every accepted output word with the oldest queued one.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [srsw_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [srsw_pkg::SeqBits-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        command_i,
  input  logic [srsw_pkg::SeqBits-1:0]      ack_frame_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [1:0]                        kind_i,
  input  logic [srsw_pkg::SeqBits-1:0]      frame_number_i,
  input  logic [srsw_pkg::SeqBits-1:0]      send_base_i,
  input  logic                              accepted_i,
  input  logic                              all_done_i,
  input  logic                              last_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output logic [srsw_pkg::SeqBits-1:0]      base_o
);

  typedef struct packed {
    logic [1:0]                   kind;
    logic [srsw_pkg::SeqBits-1:0] frame_number;
    logic [srsw_pkg::SeqBits-1:0] send_base;
    logic                         accepted;
    logic                         all_done;
    logic                         last;
  } window_word_t;

  window_word_t                   due_words[$];
  logic [srsw_pkg::WinBits-1:0]   window_reg = 5'd4;
  logic [srsw_pkg::SeqBits-1:0]   total_reg = 16'd10;
  logic [srsw_pkg::SeqBits-1:0]   base_frame = '0;
  logic [srsw_pkg::SeqBits-1:0]   next_frame = '0;
  logic [srsw_pkg::MaxWindow-1:0] acked_slots = '0;
  int                             fails = 0;

  // First frame number beyond the window; out-of-range sizes are clamped.
  function automatic logic [srsw_pkg::EdgeBits-1:0] window_edge();
    logic [srsw_pkg::WinBits-1:0] span;
    span = window_reg;
    if (span == '0) span = srsw_pkg::WinBits'(1);
    if (span > srsw_pkg::MaxWindow) span = srsw_pkg::WinBits'(srsw_pkg::MaxWindow);
    return {1'b0, base_frame} + srsw_pkg::EdgeBits'(span);
  endfunction

  function automatic window_word_t status_word(logic [1:0] kind,
                                               logic [srsw_pkg::SeqBits-1:0] frame,
                                               logic acc, logic last);
    window_word_t w;
    w.kind         = kind;
    w.frame_number = frame;
    w.send_base    = base_frame;
    w.accepted     = acc;
    w.all_done     = (base_frame >= total_reg);
    w.last         = last;
    return w;
  endfunction

  task automatic predict_send();
    logic [srsw_pkg::EdgeBits-1:0] limit;
    window_word_t                  batch[$];
    window_word_t                  tail;
    int                            i;
    limit = window_edge();
    if (limit > {1'b0, total_reg}) limit = {1'b0, total_reg};
    // Frames acknowledged ahead of sending are skipped but still consumed.
    for (i = 0; i < srsw_pkg::MaxWindow && {1'b0, next_frame} < limit; i++) begin
      if (!acked_slots[next_frame[srsw_pkg::SlotBits-1:0]]) begin
        batch.push_back(status_word(srsw_pkg::KindFrame, next_frame, 1'b0, 1'b0));
      end
      next_frame = next_frame + 1'b1;
    end
    if (batch.size() == 0) begin
      batch.push_back(status_word(srsw_pkg::KindIdle, '0, 1'b0, 1'b1));
    end else begin
      tail = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[k]) due_words.push_back(batch[k]);
  endtask

  task automatic predict_ack(logic [srsw_pkg::SeqBits-1:0] frame);
    logic acc;
    int   i;
    acc = 1'b0;
    if (frame >= base_frame && {1'b0, frame} < window_edge() && frame < total_reg &&
        !acked_slots[frame[srsw_pkg::SlotBits-1:0]]) begin
      acked_slots[frame[srsw_pkg::SlotBits-1:0]] = 1'b1;
      acc = 1'b1;
      for (i = 0; i < srsw_pkg::MaxWindow && base_frame < total_reg &&
                  acked_slots[base_frame[srsw_pkg::SlotBits-1:0]]; i++) begin
        acked_slots[base_frame[srsw_pkg::SlotBits-1:0]] = 1'b0;
        base_frame = base_frame + 1'b1;
      end
    end
    due_words.push_back(status_word(srsw_pkg::KindAck, '0, acc, 1'b1));
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic check_word();
    window_word_t want;
    if (due_words.size() == 0) begin
      $error("unexpected word: kind %0d frame %0d base %0d", kind_i, frame_number_i,
             send_base_i);
      fails++;
    end else begin
      want = due_words.pop_front();
      compare_field("kind", 32'(want.kind), 32'(kind_i));
      compare_field("frame_number", 32'(want.frame_number), 32'(frame_number_i));
      compare_field("send_base", 32'(want.send_base), 32'(send_base_i));
      compare_field("accepted", 32'(want.accepted), 32'(accepted_i));
      compare_field("all_done", 32'(want.all_done), 32'(all_done_i));
      compare_field("last", 32'(want.last), 32'(last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_reg  = 5'd4;
      total_reg   = 16'd10;
      base_frame  = '0;
      next_frame  = '0;
      acked_slots = '0;
      due_words.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == srsw_pkg::RegWindow) begin
          window_reg = cfg_data_i[srsw_pkg::WinBits-1:0];
        end else if (cfg_index_i == srsw_pkg::RegTotal) begin
          total_reg = cfg_data_i;
        end
      end
      // Commands are taken before outputs so a same-edge word finds its entry.
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          srsw_pkg::CmdSend: begin
            predict_send();
          end
          srsw_pkg::CmdAck: begin
            predict_ack(ack_frame_i);
          end
          srsw_pkg::CmdRestart: begin
            base_frame  = '0;
            next_frame  = '0;
            acked_slots = '0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) check_word();
    end
    fail_count_o <= fails;
    pending_o    <= due_words.size();
    base_o       <= base_frame;
  end

endmodule

// ===== test/selective_repeat_sender_window_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_test
// Stimulus and verdict for the selective-repeat sender window. A directed
// walk through a short transfer is followed by random phases, each under a
// new window size and frame total, with random gaps on the command side and
// random stalls on the result side except in one calm phase. A separate checker compares.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_test;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int         Phases    = 6;
  localparam int         PhaseLen  = 23;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [srsw_pkg::CfgIdxBits-1:0] cfg_index_i = '0;
  logic [srsw_pkg::SeqBits-1:0]    cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [1:0]                      command_i = srsw_pkg::CmdSend;
  logic [srsw_pkg::SeqBits-1:0]    ack_frame_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      kind_o;
  logic [srsw_pkg::SeqBits-1:0]    frame_number_o;
  logic [srsw_pkg::SeqBits-1:0]    send_base_o;
  logic                            accepted_o;
  logic                            all_done_o;
  logic                            last_o;

  int                              fail_count;
  int                              pending;
  logic [srsw_pkg::SeqBits-1:0]    base_now;
  logic                            calm = 1'b0;
  int unsigned                     total_now = 10;

  selective_repeat_sender_window dut (.*);

  selective_repeat_sender_window_checker window_check (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .in_valid_i,
    .in_stall_i     (in_stall_o),
    .command_i, .ack_frame_i,
    .out_valid_i    (out_valid_o),
    .out_stall_i,
    .kind_i         (kind_o),
    .frame_number_i (frame_number_o),
    .send_base_i    (send_base_o),
    .accepted_i     (accepted_o),
    .all_done_i     (all_done_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .base_o         (base_now)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 8);
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  task automatic put_word(logic [1:0] cmd, logic [srsw_pkg::SeqBits-1:0] frame);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    ack_frame_i <= frame;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [srsw_pkg::CfgIdxBits-1:0] idx,
                           logic [srsw_pkg::SeqBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == srsw_pkg::RegTotal) total_now = 32'(data);
  endtask

  // Holds the command side until every word has come out and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (base_now >= total_now && pick < 40) begin
      put_word(srsw_pkg::CmdRestart, srsw_pkg::SeqBits'($urandom));
    end else if (pick < 45) begin
      put_word(srsw_pkg::CmdSend, srsw_pkg::SeqBits'($urandom));
    end else if (pick < 85) begin
      put_word(srsw_pkg::CmdAck, srsw_pkg::SeqBits'(base_now + $urandom_range(0, 17)));
    end else if (pick < 90) begin
      put_word(srsw_pkg::CmdAck, srsw_pkg::SeqBits'(base_now - $urandom_range(1, 3)));
    end else if (pick < 95) begin
      put_word(srsw_pkg::CmdAck, srsw_pkg::SeqBits'($urandom));
    end else if (pick < 98) begin
      put_word(srsw_pkg::CmdRestart, srsw_pkg::SeqBits'($urandom));
    end else begin
      put_word(CmdUnused, srsw_pkg::SeqBits'($urandom));
    end
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short transfer of ten frames through a window of four.
    put_word(srsw_pkg::CmdSend, 16'h0000);
    put_word(srsw_pkg::CmdSend, 16'hffff);
    put_word(srsw_pkg::CmdAck, 16'd2);
    put_word(srsw_pkg::CmdAck, 16'd2);
    put_word(srsw_pkg::CmdAck, 16'hffff);
    put_word(srsw_pkg::CmdAck, 16'd4);
    put_word(srsw_pkg::CmdAck, 16'd0);
    put_word(srsw_pkg::CmdAck, 16'd1);
    put_word(srsw_pkg::CmdSend, 16'd0);
    put_word(srsw_pkg::CmdAck, 16'd6);
    put_word(CmdUnused, 16'd6);
    put_word(srsw_pkg::CmdAck, 16'd3);
    put_word(srsw_pkg::CmdAck, 16'd5);
    put_word(srsw_pkg::CmdSend, 16'd0);
    put_word(srsw_pkg::CmdAck, 16'd4);
    put_word(srsw_pkg::CmdAck, 16'd7);
    put_word(srsw_pkg::CmdAck, 16'd9);
    put_word(srsw_pkg::CmdSend, 16'd0);
    put_word(srsw_pkg::CmdAck, 16'd8);
    put_word(srsw_pkg::CmdSend, 16'd0);
    put_word(srsw_pkg::CmdAck, 16'd10);
    settle();
    // Total lowered below the base: the transfer reads as finished.
    write_reg(srsw_pkg::RegTotal, 16'd5);
    put_word(srsw_pkg::CmdSend, 16'd0);
    put_word(srsw_pkg::CmdAck, 16'd3);
    put_word(srsw_pkg::CmdRestart, 16'd0);
    put_word(srsw_pkg::CmdSend, 16'd0);

    for (int p = 0; p < Phases; p++) begin
      settle();
      calm = (p == 2);
      case (p)
        0: begin
          write_reg(srsw_pkg::RegWindow, 16'd0);
          write_reg(srsw_pkg::RegTotal, 16'($urandom_range(8, 40)));
        end
        1: begin
          write_reg(srsw_pkg::RegWindow, 16'd31);
          write_reg(srsw_pkg::RegTotal, 16'hffff);
        end
        2: begin
          write_reg(srsw_pkg::RegWindow, 16'd16);
          write_reg(srsw_pkg::RegTotal, 16'($urandom_range(20, 60)));
        end
        3: begin
          write_reg(srsw_pkg::RegWindow, 16'd1);
          write_reg(srsw_pkg::RegTotal, 16'd1);
        end
        4: begin
          write_reg(srsw_pkg::RegWindow, 16'($urandom_range(2, 15)));
          write_reg(srsw_pkg::RegTotal, 16'($urandom_range(1, 100)));
        end
        default: begin
          write_reg(srsw_pkg::RegWindow, 16'($urandom_range(0, 31)));
          write_reg(srsw_pkg::RegTotal, 16'($urandom_range(1, 65535)));
        end
      endcase
      for (int n = 0; n < PhaseLen; n++) random_item();
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (pending != 0) $error("%0d expected words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
